[sv/pts_pkg.sv]
// Operation/status codes, register indexes and result word type of the scheduler.
package pts_pkg;

   // operation codes carried on req_tuser
   localparam logic [2:0] OP_ADD    = 3'd0;
   localparam logic [2:0] OP_REMOVE = 3'd1;
   localparam logic [2:0] OP_SETEN  = 3'd2;
   localparam logic [2:0] OP_TICK   = 3'd3;
   localparam logic [2:0] OP_STEP   = 3'd4;

   // status codes carried on rsp_tuser
   localparam logic [1:0] ST_DONE     = 2'd0;
   localparam logic [1:0] ST_FIRED    = 2'd1;
   localparam logic [1:0] ST_NOTFOUND = 2'd2;
   localparam logic [1:0] ST_FULL     = 2'd3;

   // configuration register indexes
   localparam logic REG_FIXED_MODE  = 1'b0;
   localparam logic REG_FIXED_VALUE = 1'b1;

   // one result word before it goes to the output register
   typedef struct packed {
      logic [1:0]  status;
      logic [7:0]  fired_id;
      logic [31:0] delta_time;
      logic        expired;
      logic        last_result;
   } res_type;

endpackage

[sv/pts_ram.sv]
// Generic single-port-write, single-port-read RAM with registered read data.
module pts_ram #(
   parameter int WIDTH = 8,
   parameter int DEPTH = 16
) (
   input  logic                     clock,
   input  logic                     we,
   input  logic [$clog2(DEPTH)-1:0] waddr,
   input  logic [WIDTH-1:0]         wdata,
   input  logic [$clog2(DEPTH)-1:0] raddr,
   output logic [WIDTH-1:0]         rdata
);

   logic [WIDTH-1:0] mem_ff [DEPTH];
   logic [WIDTH-1:0] rdata_ff;

   // write port and registered read port
   always_ff @(posedge clock) begin
      if (we) begin
         mem_ff[waddr] <= wdata;
      end
      rdata_ff <= mem_ff[raddr];
   end

   assign rdata = rdata_ff;

endmodule

[sv/periodic_task_tick_scheduler_core.sv]
// Periodic task scheduler core: slot table in RAM, ordered lists, tick walk sequencer.
//
//  channel | direction | handshake             | payload
//  req     | in        | req_tvalid/req_tready | tuser=operation, tdata=task fields
//  rsp     | out       | rsp_tvalid/rsp_tready | tuser=status, tlast=last_result, tdata
//  csr     | in        | APB, pready always 1  | fixed_step_mode @0, fixed_step_value @4
//
// One word is worked on at a time; req_tready is high only while the sequencer is idle.
// Add passes start and emit; remove/set enable/step read and compare each entry searched.
// A tick merges the pending entries, then reads and processes each main entry walked,
// plus a multiply, write back and emit per fire; each result waits while rsp is stalled.
// Reset (synchronous) clears counts, busy bits and timing state; the RAM needs no clear.
module periodic_task_tick_scheduler_core #(
   parameter int SLOTS   = 16,
   parameter int ID_BITS = 8
) (
   input  logic        clock,
   input  logic        reset,
   // input words
   input  logic        req_tvalid,
   output logic        req_tready,
   input  logic [2:0]  req_tuser,  // operation
   // task_id[7:0], tick_period[23:8], run_count[39:24], enable_value[40],
   // now_time[72:41], time_scale[88:73], zero[95:89]
   input  logic [95:0] req_tdata,
   // result words
   output logic        rsp_tvalid,
   input  logic        rsp_tready,
   output logic [1:0]  rsp_tuser,  // status
   output logic        rsp_tlast,  // last_result
   // fired_id[7:0], delta_time[39:8], expired[40], zero[47:41]
   output logic [47:0] rsp_tdata,
   // configuration
   input  logic        csr_psel,
   input  logic        csr_penable,
   input  logic        csr_pwrite,
   input  logic [2:0]  csr_paddr,
   input  logic [31:0] csr_pwdata,
   output logic [31:0] csr_prdata,
   output logic        csr_pready
);

   localparam int IW = (SLOTS > 1) ? $clog2(SLOTS) : 1;
   localparam int CW = $clog2(SLOTS + 1);

   typedef struct packed {
      logic [ID_BITS-1:0] id;
      logic [15:0]        period;
      logic [15:0]        countdown;
      logic [15:0]        runs;
      logic               enabled;
      logic [31:0]        last_time;
   } slot_type;

   localparam int SW = $bits(slot_type);

   typedef enum logic [3:0] {
      S_IDLE, S_START, S_MERGE, S_WALK_RD, S_WALK_PROC, S_SRCH_RD, S_SRCH_CMP,
      S_MUL, S_FIRE, S_EMIT
   } state_type;

   // registers
   state_type           state_ff, state_in, ret_ff, ret_in;
   logic [2:0]          op_ff, op_in;
   logic [ID_BITS-1:0]  id_ff, id_in;
   logic [15:0]         per_ff, per_in;
   logic [15:0]         runs_ff, runs_in;
   logic                en_ff, en_in;
   logic [31:0]         now_ff, now_in;
   logic [15:0]         scale_ff, scale_in;
   logic                mode_ff, mode_in;
   logic [31:0]         fixval_ff, fixval_in;
   logic                started_ff, started_in;
   logic                stamp_ff, stamp_in;
   logic                lst_ff, lst_in;    // 0 main list, 1 pending list
   logic                tick_ff, tick_in;  // fire belongs to a tick walk
   logic [CW-1:0]       idx_ff, idx_in;
   logic [CW-1:0]       mcnt_ff, mcnt_in;
   logic [CW-1:0]       pcnt_ff, pcnt_in;
   logic [IW-1:0]       slot_ff, slot_in;
   logic [SLOTS-1:0]    busy_ff, busy_in;
   logic [IW-1:0]       mord_ff [SLOTS];
   logic [IW-1:0]       mord_in [SLOTS];
   logic [IW-1:0]       pord_ff [SLOTS];
   logic [IW-1:0]       pord_in [SLOTS];
   slot_type            cur_ff, cur_in;
   logic [47:0]         prod_ff, prod_in;
   logic                neg_ff, neg_in;
   pts_pkg::res_type    res_ff, res_in;
   logic                rv_ff, rv_in;
   pts_pkg::res_type    rsp_ff, rsp_in;

   // RAM ports
   logic                ram_we;
   logic [IW-1:0]       ram_waddr, ram_raddr;
   slot_type            ram_wdata, ram_rdata;
   logic [SW-1:0]       ram_rbits;

   // helpers
   logic [IW-1:0]       free_slot;
   logic                free_ok;
   logic [CW:0]         total;
   logic [31:0]         tid32;
   logic [35:0]         shifted;
   logic [31:0]         delta;
   logic [15:0]         cd_dec;
   logic [CW-1:0]       lst_cnt;
   slot_type            ent;
   logic                csr_wr;

   pts_ram #(.WIDTH(SW), .DEPTH(SLOTS)) u_slots (
      .clock (clock),
      .we    (ram_we),
      .waddr (ram_waddr),
      .wdata (ram_wdata),
      .raddr (ram_raddr),
      .rdata (ram_rbits)
   );
   assign ram_rdata = slot_type'(ram_rbits);

   // lowest free slot
   always_comb begin
      free_slot = '0;
      free_ok   = 1'b0;
      for (int j = SLOTS - 1; j >= 0; j--) begin
         if (!busy_ff[j]) begin
            free_slot = IW'(j);
            free_ok   = 1'b1;
         end
      end
   end

   assign total   = {1'b0, mcnt_ff} + {1'b0, pcnt_ff};
   assign tid32   = {24'd0, req_tdata[7:0]};
   assign shifted = prod_ff[47:12];
   assign delta   = mode_ff ? fixval_ff :
                    neg_ff  ? 32'd0 :
                    (|shifted[35:32]) ? 32'hFFFF_FFFF : shifted[31:0];
   assign cd_dec  = ram_rdata.countdown - 16'd1;
   assign lst_cnt = lst_ff ? pcnt_ff : mcnt_ff;
   assign csr_wr  = csr_psel && csr_penable && csr_pwrite;

   // RAM read address follows the list entry under the walk or search index
   always_comb begin
      if (state_ff == S_SRCH_RD && lst_ff) begin
         ram_raddr = pord_ff[idx_ff[IW-1:0]];
      end else begin
         ram_raddr = mord_ff[idx_ff[IW-1:0]];
      end
   end

   // sequencer next state
   always_comb begin
      state_in   = state_ff;
      ret_in     = ret_ff;
      op_in      = op_ff;
      id_in      = id_ff;
      per_in     = per_ff;
      runs_in    = runs_ff;
      en_in      = en_ff;
      now_in     = now_ff;
      scale_in   = scale_ff;
      mode_in    = mode_ff;
      fixval_in  = fixval_ff;
      started_in = started_ff;
      stamp_in   = stamp_ff;
      lst_in     = lst_ff;
      tick_in    = tick_ff;
      idx_in     = idx_ff;
      mcnt_in    = mcnt_ff;
      pcnt_in    = pcnt_ff;
      slot_in    = slot_ff;
      busy_in    = busy_ff;
      mord_in    = mord_ff;
      pord_in    = pord_ff;
      cur_in     = cur_ff;
      prod_in    = prod_ff;
      neg_in     = neg_ff;
      res_in     = res_ff;
      rv_in      = rv_ff;
      rsp_in     = rsp_ff;
      ram_we     = 1'b0;
      ram_waddr  = slot_ff;
      ram_wdata  = ram_rdata;
      ent        = ram_rdata;

      // configuration writes
      if (csr_wr) begin
         if (csr_paddr[2] == pts_pkg::REG_FIXED_MODE) begin
            mode_in = csr_pwdata[0];
         end else begin
            fixval_in = csr_pwdata;
         end
      end

      // output register drains independently
      if (rv_ff && rsp_tready) begin
         rv_in = 1'b0;
      end

      unique case (state_ff)
         S_IDLE: begin
            if (req_tvalid) begin
               op_in    = req_tuser;
               id_in    = tid32[ID_BITS-1:0];
               per_in   = req_tdata[23:8];
               runs_in  = req_tdata[39:24];
               en_in    = req_tdata[40];
               now_in   = req_tdata[72:41];
               scale_in = req_tdata[88:73];
               state_in = S_START;
            end
         end
         S_START: begin
            idx_in = '0;
            res_in = '{status: pts_pkg::ST_DONE, fired_id: 8'd0, delta_time: 32'd0,
                       expired: 1'b0, last_result: 1'b1};
            ret_in = S_IDLE;
            case (op_ff)
               pts_pkg::OP_ADD: begin
                  if (total >= (CW+1)'(SLOTS) || !free_ok) begin
                     res_in.status = pts_pkg::ST_FULL;
                  end else begin
                     ram_we     = 1'b1;
                     ram_waddr  = free_slot;
                     ram_wdata  = '{id: id_ff, period: per_ff, countdown: per_ff,
                                    runs: runs_ff, enabled: 1'b1, last_time: 32'd0};
                     busy_in[free_slot] = 1'b1;
                     pord_in[pcnt_ff[IW-1:0]] = free_slot;
                     pcnt_in    = pcnt_ff + CW'(1);
                  end
                  state_in = S_EMIT;
               end
               pts_pkg::OP_REMOVE, pts_pkg::OP_STEP: begin
                  lst_in   = 1'b0;
                  state_in = S_SRCH_RD;
               end
               pts_pkg::OP_SETEN: begin
                  lst_in   = 1'b1;
                  state_in = S_SRCH_RD;
               end
               pts_pkg::OP_TICK: begin
                  state_in = S_MERGE;
               end
               default: begin
                  state_in = S_EMIT;
               end
            endcase
         end
         S_MERGE: begin
            // move pending entries onto the end of the main list
            if (idx_ff < pcnt_ff) begin
               mord_in[mcnt_ff[IW-1:0]] = pord_ff[idx_ff[IW-1:0]];
               mcnt_in = mcnt_ff + CW'(1);
               idx_in  = idx_ff + CW'(1);
            end else begin
               pcnt_in = '0;
               idx_in  = '0;
               tick_in = 1'b1;
               if (!started_ff && !mode_ff) begin
                  started_in = 1'b1;
                  stamp_in   = 1'b1;
               end else begin
                  stamp_in = 1'b0;
               end
               state_in = S_WALK_RD;
            end
         end
         S_WALK_RD: begin
            if (idx_ff >= mcnt_ff) begin
               res_in = '{status: pts_pkg::ST_DONE, fired_id: 8'd0, delta_time: 32'd0,
                          expired: 1'b0, last_result: 1'b1};
               ret_in   = S_IDLE;
               state_in = S_EMIT;
            end else begin
               slot_in  = ram_raddr;
               state_in = S_WALK_PROC;
            end
         end
         S_WALK_PROC: begin
            state_in = S_WALK_RD;
            if (stamp_ff) begin
               ram_we              = 1'b1;
               ram_wdata.last_time = now_ff;
               idx_in              = idx_ff + CW'(1);
            end else if (ram_rdata.enabled) begin
               if (cd_dec == 16'd0) begin
                  cur_in   = ram_rdata;
                  state_in = S_MUL;
               end else begin
                  ram_we              = 1'b1;
                  ram_wdata.countdown = cd_dec;
                  idx_in              = idx_ff + CW'(1);
               end
            end else begin
               idx_in = idx_ff + CW'(1);
            end
         end
         S_SRCH_RD: begin
            if (idx_ff >= lst_cnt) begin
               idx_in = '0;
               if (op_ff == pts_pkg::OP_REMOVE && !lst_ff) begin
                  lst_in = 1'b1;
               end else if (op_ff == pts_pkg::OP_SETEN && lst_ff) begin
                  lst_in = 1'b0;
               end else begin
                  res_in = '{status: pts_pkg::ST_NOTFOUND, fired_id: 8'd0,
                             delta_time: 32'd0, expired: 1'b0, last_result: 1'b1};
                  ret_in   = S_IDLE;
                  state_in = S_EMIT;
               end
            end else begin
               slot_in  = ram_raddr;
               state_in = S_SRCH_CMP;
            end
         end
         S_SRCH_CMP: begin
            if (ram_rdata.id == id_ff) begin
               res_in = '{status: pts_pkg::ST_DONE, fired_id: 8'd0, delta_time: 32'd0,
                          expired: 1'b0, last_result: 1'b1};
               ret_in   = S_IDLE;
               state_in = S_EMIT;
               case (op_ff)
                  pts_pkg::OP_REMOVE: begin
                     busy_in[slot_ff] = 1'b0;
                     if (lst_ff) begin
                        for (int j = 0; j < SLOTS - 1; j++) begin
                           if (CW'(j) >= idx_ff) pord_in[j] = pord_ff[j+1];
                        end
                        pcnt_in = pcnt_ff - CW'(1);
                     end else begin
                        for (int j = 0; j < SLOTS - 1; j++) begin
                           if (CW'(j) >= idx_ff) mord_in[j] = mord_ff[j+1];
                        end
                        mcnt_in = mcnt_ff - CW'(1);
                     end
                  end
                  pts_pkg::OP_SETEN: begin
                     ram_we            = 1'b1;
                     ram_wdata.enabled = en_ff;
                  end
                  default: begin
                     // step one task
                     cur_in   = ram_rdata;
                     tick_in  = 1'b0;
                     state_in = S_MUL;
                  end
               endcase
            end else begin
               idx_in   = idx_ff + CW'(1);
               state_in = S_SRCH_RD;
            end
         end
         S_MUL: begin
            prod_in  = 48'((now_ff - cur_ff.last_time)) * 48'(scale_ff);
            neg_in   = now_ff < cur_ff.last_time;
            state_in = S_FIRE;
         end
         S_FIRE: begin
            ent           = cur_ff;
            ent.last_time = now_ff;
            ent.countdown = cur_ff.period;
            if (cur_ff.runs != 16'd0) ent.runs = cur_ff.runs - 16'd1;
            ram_we    = 1'b1;
            ram_wdata = ent;
            res_in = '{status: pts_pkg::ST_FIRED, fired_id: 8'(cur_ff.id),
                       delta_time: delta, expired: 1'b0, last_result: !tick_ff};
            if (cur_ff.runs == 16'd1) begin
               // expired: leave the main list, the next entry slides into place
               res_in.expired   = 1'b1;
               busy_in[slot_ff] = 1'b0;
               for (int j = 0; j < SLOTS - 1; j++) begin
                  if (CW'(j) >= idx_ff) mord_in[j] = mord_ff[j+1];
               end
               mcnt_in = mcnt_ff - CW'(1);
            end else if (tick_ff) begin
               idx_in = idx_ff + CW'(1);
            end
            ret_in   = tick_ff ? S_WALK_RD : S_IDLE;
            state_in = S_EMIT;
         end
         S_EMIT: begin
            if (!rv_ff || rsp_tready) begin
               rsp_in   = res_ff;
               rv_in    = 1'b1;
               state_in = ret_ff;
            end
         end
         default: begin
            state_in = S_IDLE;
         end
      endcase
   end

   // state and registered outputs
   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff   <= S_IDLE;
         ret_ff     <= S_IDLE;
         mode_ff    <= 1'b0;
         fixval_ff  <= 32'd0;
         started_ff <= 1'b0;
         mcnt_ff    <= '0;
         pcnt_ff    <= '0;
         busy_ff    <= '0;
         rv_ff      <= 1'b0;
      end else begin
         state_ff   <= state_in;
         ret_ff     <= ret_in;
         mode_ff    <= mode_in;
         fixval_ff  <= fixval_in;
         started_ff <= started_in;
         mcnt_ff    <= mcnt_in;
         pcnt_ff    <= pcnt_in;
         busy_ff    <= busy_in;
         rv_ff      <= rv_in;
      end
      op_ff    <= op_in;
      id_ff    <= id_in;
      per_ff   <= per_in;
      runs_ff  <= runs_in;
      en_ff    <= en_in;
      now_ff   <= now_in;
      scale_ff <= scale_in;
      stamp_ff <= stamp_in;
      lst_ff   <= lst_in;
      tick_ff  <= tick_in;
      idx_ff   <= idx_in;
      slot_ff  <= slot_in;
      mord_ff  <= mord_in;
      pord_ff  <= pord_in;
      cur_ff   <= cur_in;
      prod_ff  <= prod_in;
      neg_ff   <= neg_in;
      res_ff   <= res_in;
      rsp_ff   <= rsp_in;
   end

   assign req_tready = (state_ff == S_IDLE);
   assign rsp_tvalid = rv_ff;
   assign rsp_tuser  = rsp_ff.status;
   assign rsp_tlast  = rsp_ff.last_result;
   assign rsp_tdata  = {7'd0, rsp_ff.expired, rsp_ff.delta_time, rsp_ff.fired_id};
   assign csr_prdata = (csr_paddr[2] == pts_pkg::REG_FIXED_MODE) ? {31'd0, mode_ff}
                                                                : fixval_ff;
   assign csr_pready = 1'b1;

endmodule

[sv/pts_checker.sv]
// Port-level checker for the tick scheduler core, bound to the top level.
module pts_checker (
   input logic        clock,
   input logic        reset,
   input logic        rsp_tvalid,
   input logic        rsp_tready,
   input logic [1:0]  rsp_tuser,
   input logic        rsp_tlast,
   input logic [47:0] rsp_tdata,
   input logic        csr_pready
);

   // no result word right after reset
   assert property (@(posedge clock) reset |=> !rsp_tvalid)
      else $error("result valid after reset");

   // a stalled result word holds
   assert property (@(posedge clock) disable iff (reset)
      rsp_tvalid && !rsp_tready |=> $stable(rsp_tdata) && rsp_tvalid)
      else $error("stalled result changed");

   // only a fire carries id, delta and expiry, and every other result is last
   assert property (@(posedge clock) disable iff (reset)
      rsp_tvalid && rsp_tuser != pts_pkg::ST_FIRED |-> rsp_tdata == 48'd0 && rsp_tlast)
      else $error("non-fire result carries payload or is not last");

   // the configuration port never waits
   assert property (@(posedge clock) disable iff (reset) csr_pready)
      else $error("pready low");

endmodule

bind periodic_task_tick_scheduler_core pts_checker u_pts_checker (
   .clock      (clock),
   .reset      (reset),
   .rsp_tvalid (rsp_tvalid),
   .rsp_tready (rsp_tready),
   .rsp_tuser  (rsp_tuser),
   .rsp_tlast  (rsp_tlast),
   .rsp_tdata  (rsp_tdata),
   .csr_pready (csr_pready)
);

[tb/periodic_task_tick_scheduler_core_check.sv]
// Checker for the tick scheduler: watches req, rsp and csr, predicts and compares results.
module periodic_task_tick_scheduler_core_check (
   input  logic        clock,
   input  logic        reset,
   input  logic        req_tvalid,
   input  logic        req_tready,
   input  logic [2:0]  req_tuser,
   input  logic [95:0] req_tdata,
   input  logic        rsp_tvalid,
   input  logic        rsp_tready,
   input  logic [1:0]  rsp_tuser,
   input  logic        rsp_tlast,
   input  logic [47:0] rsp_tdata,
   input  logic        csr_psel,
   input  logic        csr_penable,
   input  logic        csr_pwrite,
   input  logic [2:0]  csr_paddr,
   input  logic [31:0] csr_pwdata,
   output int          fail_count,
   output int          pending_results
);
   timeunit 1ns;
   timeprecision 1ps;

   localparam int NSLOT = 16;

   // scheduler model state
   logic [7:0]  tid [NSLOT];
   logic [15:0] tper [NSLOT];
   logic [15:0] tcnt [NSLOT];
   logic [15:0] truns [NSLOT];
   logic        ten [NSLOT];
   logic [31:0] tlast_t [NSLOT];
   logic        tbusy [NSLOT];
   int          main_q[$];
   int          pend_q[$];
   logic        started;
   logic        fmode;
   logic [31:0] fvalue;

   pts_pkg::res_type sched_results[$];

   function automatic logic [31:0] scaled_delta(logic [31:0] now, logic [31:0] last,
                                                logic [15:0] scale);
      logic [63:0] p;
      if (now < last) return 32'd0;
      p = ({32'd0, now - last} * {48'd0, scale}) >> 12;
      return (p > 64'hFFFF_FFFF) ? 32'hFFFF_FFFF : p[31:0];
   endfunction

   function automatic int find_slot(ref int q[$], input logic [7:0] id);
      for (int i = 0; i < q.size(); i++)
         if (tid[q[i]] == id) return i;
      return -1;
   endfunction

   // append one expected result word
   function automatic void expect_word(input pts_pkg::res_type r);
      sched_results.insert(sched_results.size(), r);
   endfunction

   // fire main entry pos; sets r.expired when the task expired and left
   task automatic fire_task(input int pos, input logic [31:0] now, input logic [15:0] scale,
                            output pts_pkg::res_type r);
      int s;
      s = main_q[pos];
      r = '0;
      r.status = pts_pkg::ST_FIRED;
      r.fired_id = tid[s];
      r.delta_time = fmode ? fvalue : scaled_delta(now, tlast_t[s], scale);
      tlast_t[s] = now;
      tcnt[s] = tper[s];
      if (truns[s] != 0) begin
         truns[s]--;
         if (truns[s] == 0) begin
            tbusy[s] = 1'b0;
            main_q.delete(pos);
            r.expired = 1'b1;
         end
      end
   endtask

   task automatic predict_word(input logic [2:0] op, input logic [95:0] d);
      logic [7:0]       id;
      logic [31:0]      now;
      logic [15:0]      scale;
      pts_pkg::res_type r;
      int               pos, s, i;
      id = d[7:0];
      now = d[72:41];
      scale = d[88:73];
      r = '0;
      r.last_result = 1'b1;
      case (op)
         pts_pkg::OP_ADD: begin
            s = -1;
            if (main_q.size() + pend_q.size() < NSLOT)
               for (i = NSLOT - 1; i >= 0; i--) if (!tbusy[i]) s = i;
            if (s < 0) r.status = pts_pkg::ST_FULL;
            else begin
               tbusy[s] = 1'b1;
               tid[s] = id;
               tper[s] = d[23:8];
               tcnt[s] = d[23:8];
               truns[s] = d[39:24];
               ten[s] = 1'b1;
               tlast_t[s] = '0;
               pend_q.insert(pend_q.size(), s);
            end
            expect_word(r);
         end
         pts_pkg::OP_REMOVE: begin
            pos = find_slot(main_q, id);
            if (pos >= 0) begin
               tbusy[main_q[pos]] = 1'b0;
               main_q.delete(pos);
            end else begin
               pos = find_slot(pend_q, id);
               if (pos >= 0) begin
                  tbusy[pend_q[pos]] = 1'b0;
                  pend_q.delete(pos);
               end else r.status = pts_pkg::ST_NOTFOUND;
            end
            expect_word(r);
         end
         pts_pkg::OP_SETEN: begin
            pos = find_slot(pend_q, id);
            if (pos >= 0) ten[pend_q[pos]] = d[40];
            else begin
               pos = find_slot(main_q, id);
               if (pos >= 0) ten[main_q[pos]] = d[40];
               else r.status = pts_pkg::ST_NOTFOUND;
            end
            expect_word(r);
         end
         pts_pkg::OP_TICK: begin
            foreach (pend_q[k]) main_q.insert(main_q.size(), pend_q[k]);
            pend_q.delete();
            if (!started && !fmode) begin
               started = 1'b1;
               foreach (main_q[k]) tlast_t[main_q[k]] = now;
            end else begin
               i = 0;
               while (i < main_q.size()) begin
                  s = main_q[i];
                  if (ten[s]) begin
                     tcnt[s]--;
                     if (tcnt[s] == 0) begin
                        fire_task(i, now, scale, r);
                        expect_word(r);
                        if (r.expired) continue;
                     end
                  end
                  i++;
               end
            end
            r = '0;
            r.last_result = 1'b1;
            expect_word(r);
         end
         pts_pkg::OP_STEP: begin
            pos = find_slot(main_q, id);
            if (pos < 0) r.status = pts_pkg::ST_NOTFOUND;
            else begin
               fire_task(pos, now, scale, r);
               r.last_result = 1'b1;
            end
            expect_word(r);
         end
         default: expect_word(r);
      endcase
   endtask

   always @(posedge clock) begin
      pts_pkg::res_type got, want;
      if (reset) begin
         main_q.delete();
         pend_q.delete();
         sched_results.delete();
         foreach (tbusy[k]) tbusy[k] = 1'b0;
         started = 1'b0;
         fmode = 1'b0;
         fvalue = '0;
         fail_count = 0;
      end else begin
         // register writes
         if (csr_psel && csr_penable && csr_pwrite) begin
            if (csr_paddr[2] == pts_pkg::REG_FIXED_VALUE) fvalue = csr_pwdata;
            else fmode = csr_pwdata[0];
         end
         // compare a result word
         if (rsp_tvalid && rsp_tready) begin
            got.status = rsp_tuser;
            got.fired_id = rsp_tdata[7:0];
            got.delta_time = rsp_tdata[39:8];
            got.expired = rsp_tdata[40];
            got.last_result = rsp_tlast;
            if (sched_results.size() == 0) begin
               $display("%0t: unexpected result word %p", $time, got);
               fail_count++;
            end else begin
               want = sched_results.pop_front();
               if (got !== want) begin
                  $display("%0t: mismatch expected %p actual %p", $time, want, got);
                  fail_count++;
               end
            end
         end
         if (req_tvalid && req_tready) predict_word(req_tuser, req_tdata);
      end
      pending_results = sched_results.size();
   end
endmodule

[tb/periodic_task_tick_scheduler_core_test.sv]
// Top of the tick scheduler testbench: clock, reset, stimulus and verdict.
module periodic_task_tick_scheduler_core_test;
   timeunit 1ns;
   timeprecision 1ps;

   localparam int STALL_LIMIT = 20000;

   logic        clock;
   logic        reset;
   logic        req_tvalid, req_tready;
   logic [2:0]  req_tuser;
   logic [95:0] req_tdata;
   logic        rsp_tvalid, rsp_tready;
   logic [1:0]  rsp_tuser;
   logic        rsp_tlast;
   logic [47:0] rsp_tdata;
   logic        csr_psel, csr_penable, csr_pwrite;
   logic [2:0]  csr_paddr;
   logic [31:0] csr_pwdata, csr_prdata;
   logic        csr_pready;
   int          fail_count, pending_results;
   int          idle_cycles;

   periodic_task_tick_scheduler_core dut (.*);
   periodic_task_tick_scheduler_core_check checker_i (.*);

   initial begin
      clock = 1'b0;
      forever #10 clock = ~clock;
   end

   // watchdog on cycles without any accepted word
   always @(posedge clock) begin
      if (reset || (req_tvalid && req_tready) || (rsp_tvalid && rsp_tready)
          || csr_psel) idle_cycles <= 0;
      else idle_cycles <= idle_cycles + 1;
      if (idle_cycles >= STALL_LIMIT) begin
         $display("simulation failed");
         $finish;
      end
   end

   // receiver stall pattern
   initial begin
      int gap;
      rsp_tready = 1'b0;
      forever begin
         gap = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(0, 10);
         repeat (gap) @(posedge clock) rsp_tready <= 1'b0;
         @(posedge clock) rsp_tready <= 1'b1;
         while (!(rsp_tvalid && rsp_tready)) @(posedge clock);
      end
   end

   task automatic csr_write(input logic [2:0] addr, input logic [31:0] value);
      @(posedge clock);
      csr_psel <= 1'b1; csr_penable <= 1'b0; csr_pwrite <= 1'b1;
      csr_paddr <= addr; csr_pwdata <= value;
      @(posedge clock) csr_penable <= 1'b1;
      @(posedge clock) begin csr_psel <= 1'b0; csr_penable <= 1'b0; end
   endtask

   // wait until every expected result word has come back
   task automatic drain;
      do @(negedge clock); while (pending_results != 0);
      repeat (100) @(posedge clock);
   endtask

   // send one word, idling first when asked
   task automatic send_word(input logic [2:0] op, input logic [7:0] id, input logic [15:0] per,
                            input logic [15:0] runs, input logic en, input logic [31:0] now,
                            input logic [15:0] scale, input bit gaps);
      int gap;
      gap = gaps ? $urandom_range(0, 10) : 0;
      if (gap != 0) begin
         @(posedge clock) req_tvalid <= 1'b0;
         repeat (gap - 1) @(posedge clock);
      end
      @(posedge clock);
      req_tvalid <= 1'b1;
      req_tuser <= op;
      req_tdata <= {7'd0, scale, now, en, runs, per, id};
      do @(posedge clock); while (!req_tready);
      req_tvalid <= 1'b0;
   endtask

   // random phase: mostly add/tick traffic over a small id pool
   task automatic random_phase(input int count, input logic [31:0] start_time);
      logic [31:0] now;
      logic [2:0]  op;
      int          pick;
      bit          gaps;
      now = start_time;
      gaps = 1'b1;
      for (int n = 0; n < count; n++) begin
         if (n % 40 == 0) gaps = $urandom_range(0, 3) != 0;
         pick = $urandom_range(0, 99);
         op = pick < 25 ? pts_pkg::OP_ADD : pick < 32 ? pts_pkg::OP_REMOVE :
              pick < 40 ? pts_pkg::OP_SETEN : pick < 85 ? pts_pkg::OP_TICK :
              pick < 97 ? pts_pkg::OP_STEP : 3'($urandom_range(5, 7));
         if ($urandom_range(0, 19) == 0) now = $urandom;
         else now = now + $urandom_range(0, 5000);
         send_word(op, ($urandom_range(0, 9) == 0) ? 8'($urandom) : 8'($urandom_range(0, 11)),
                   ($urandom_range(0, 9) == 0) ? 16'($urandom) : 16'($urandom_range(0, 6)),
                   ($urandom_range(0, 9) == 0) ? 16'($urandom) : 16'($urandom_range(0, 4)),
                   1'($urandom_range(0, 4) != 0), now, 16'($urandom), gaps);
      end
   endtask

   initial begin
      reset = 1'b1;
      req_tvalid = 1'b0; req_tuser = '0; req_tdata = '0;
      csr_psel = 1'b0; csr_penable = 1'b0; csr_pwrite = 1'b0;
      csr_paddr = '0; csr_pwdata = '0;
      repeat (2) @(posedge clock);
      reset <= 1'b0;

      // directed: first tick stamps, extremes of period, runs, scale and time
      send_word(pts_pkg::OP_TICK, 8'd0, 16'd0, 16'd0, 1'b0, 32'd5, 16'd0, 1'b0);
      send_word(pts_pkg::OP_ADD, 8'hFF, 16'd1, 16'd1, 1'b0, 32'd0, 16'd0, 1'b0);
      send_word(pts_pkg::OP_ADD, 8'd0, 16'd1, 16'd0, 1'b0, 32'd0, 16'd0, 1'b0);
      send_word(pts_pkg::OP_ADD, 8'd7, 16'hFFFF, 16'hFFFF, 1'b1, 32'd0, 16'd0, 1'b0);
      send_word(pts_pkg::OP_ADD, 8'd7, 16'd0, 16'd2, 1'b1, 32'd0, 16'd0, 1'b0);
      send_word(pts_pkg::OP_SETEN, 8'd7, 16'd0, 16'd0, 1'b0, 32'd0, 16'd0, 1'b0);
      send_word(pts_pkg::OP_SETEN, 8'd99, 16'd0, 16'd0, 1'b1, 32'd0, 16'd0, 1'b0);
      send_word(pts_pkg::OP_TICK, 8'd0, 16'd0, 16'd0, 1'b0, 32'hFFFF_FFFF, 16'hFFFF, 1'b0);
      send_word(pts_pkg::OP_STEP, 8'd7, 16'd0, 16'd0, 1'b0, 32'd3, 16'hFFFF, 1'b0);
      send_word(pts_pkg::OP_STEP, 8'd7, 16'd0, 16'd0, 1'b0, 32'hFFFF_FFFF, 16'hFFFF, 1'b0);
      send_word(pts_pkg::OP_STEP, 8'd55, 16'd0, 16'd0, 1'b0, 32'd0, 16'd0, 1'b0);
      send_word(pts_pkg::OP_REMOVE, 8'd0, 16'd0, 16'd0, 1'b0, 32'd0, 16'd0, 1'b0);
      send_word(pts_pkg::OP_REMOVE, 8'd200, 16'd0, 16'd0, 1'b0, 32'd0, 16'd0, 1'b0);
      send_word(3'd5, 8'd0, 16'd0, 16'd0, 1'b0, 32'd0, 16'd0, 1'b0);
      send_word(3'd7, 8'hFF, 16'hFFFF, 16'hFFFF, 1'b1, 32'hFFFF_FFFF, 16'hFFFF, 1'b0);
      // fill the table past full, then a tick with many fires and expiries
      for (int k = 0; k < 18; k++)
         send_word(pts_pkg::OP_ADD, 8'(k), 16'd1, 16'(k % 2), 1'b0, 32'd0, 16'd0, 1'b0);
      send_word(pts_pkg::OP_TICK, 8'd0, 16'd0, 16'd0, 1'b0, 32'd100, 16'h1000, 1'b0);
      send_word(pts_pkg::OP_TICK, 8'd0, 16'd0, 16'd0, 1'b0, 32'd50, 16'h1000, 1'b0);
      drain();

      random_phase(150, 32'd1000);
      drain();
      csr_write(3'd0, 32'd1);
      csr_write(3'd4, 32'hFFFF_FFFF);
      random_phase(120, 32'd0);
      drain();
      csr_write(3'd4, 32'd0);
      random_phase(60, 32'd0);
      drain();
      csr_write(3'd0, 32'd0);
      csr_write(3'd4, 32'h1234_5678);
      random_phase(150, 32'h8000_0000);
      drain();

      if (fail_count == 0) $display("simulation ok");
      else $display("simulation failed");
      $finish;
   end
endmodule
